// ===== rtl/core/rgbc_pkg.sv =====
// Package for the RGB pixel format converter: payload types, BT.601 coefficients,
// configuration register indexes and the per-stage conversion functions.
// Depends on nothing; every other file of the block imports it.
package rgbc_pkg;

  typedef logic [23:0] pixel_t;
  typedef logic [31:0] word_t;

  // Configuration port widths and register indexes.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 1;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  localparam cfg_idx_t CFG_OUTPUT_FORMAT   = 1'd0;
  localparam cfg_idx_t CFG_WORD_BYTE_ORDER = 1'd1;

  // Output format codes.
  localparam logic FMT_UYVY   = 1'b0;
  localparam logic FMT_RGB565 = 1'b1;

  // Integer BT.601 coefficients and rounding biases.
  localparam logic [15:0] CY_R   = 16'd66;
  localparam logic [15:0] CY_G   = 16'd129;
  localparam logic [15:0] CY_B   = 16'd25;
  localparam logic [15:0] CU_R   = 16'd38;
  localparam logic [15:0] CU_G   = 16'd74;
  localparam logic [15:0] CU_B   = 16'd112;
  localparam logic [15:0] CV_R   = 16'd112;
  localparam logic [15:0] CV_G   = 16'd94;
  localparam logic [15:0] CV_B   = 16'd18;
  localparam logic [15:0] Y_BIAS = 16'(16 * 256 + 128);
  localparam logic [15:0] C_BIAS = 16'(128 * 256 + 128);

  // Products of one pixel, plus its RGB565 halfword carried alongside.
  typedef struct packed {
    logic [15:0] y_r;
    logic [15:0] y_g;
    logic [15:0] y_b;
    logic [15:0] u_r;
    logic [15:0] u_g;
    logic [15:0] u_b;
    logic [15:0] v_r;
    logic [15:0] v_g;
    logic [15:0] v_b;
    logic [15:0] rgb565;
  } prod_t;

  // Finished components of one pixel.
  typedef struct packed {
    logic [7:0]  y;
    logic [7:0]  u;
    logic [7:0]  v;
    logic [15:0] rgb565;
  } yuv_t;

  function automatic prod_t pixel_products(pixel_t px);
    prod_t       p;
    logic [15:0] r;
    logic [15:0] g;
    logic [15:0] b;
    r = {8'd0, px[23:16]};
    g = {8'd0, px[15:8]};
    b = {8'd0, px[7:0]};
    p.y_r    = r * CY_R;
    p.y_g    = g * CY_G;
    p.y_b    = b * CY_B;
    p.u_r    = r * CU_R;
    p.u_g    = g * CU_G;
    p.u_b    = b * CU_B;
    p.v_r    = r * CV_R;
    p.v_g    = g * CV_G;
    p.v_b    = b * CV_B;
    p.rgb565 = {px[23:19], px[15:10], px[7:3]};
    return p;
  endfunction

  // The true sums always lie in 0..65535, so modulo-2^16 arithmetic is exact.
  function automatic yuv_t pixel_sums(prod_t p);
    yuv_t        c;
    logic [15:0] ys;
    logic [15:0] us;
    logic [15:0] vs;
    ys = p.y_r + p.y_g + p.y_b + Y_BIAS;
    us = p.u_b + C_BIAS - p.u_r - p.u_g;
    vs = p.v_r + C_BIAS - p.v_g - p.v_b;
    c.y      = ys[15:8];
    c.u      = us[15:8];
    c.v      = vs[15:8];
    c.rgb565 = p.rgb565;
    return c;
  endfunction

  function automatic word_t pixel_pack(yuv_t c, logic fmt, logic big);
    word_t w;
    if (fmt == FMT_RGB565) begin
      w = {16'd0, c.rgb565};
    end else if (big) begin
      w = {c.u, c.y, c.v, c.y};
    end else begin
      w = {c.y, c.v, c.y, c.u};
    end
    return w;
  endfunction

endpackage

// ===== rtl/core/rgbc_ifs.sv =====
// Channel interfaces of the RGB pixel format converter: pixel pair input,
// converted word output and configuration write channel. Depends on rgbc_pkg.
interface rgbc_pix_if import rgbc_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t pixel_first;
  pixel_t pixel_second;

  modport source (output valid, output pixel_first, output pixel_second, input ready);
  modport sink   (input valid, input pixel_first, input pixel_second, output ready);
endinterface

interface rgbc_word_if import rgbc_pkg::*; ();
  logic  valid;
  logic  ready;
  word_t word_first;
  word_t word_second;

  modport source (output valid, output word_first, output word_second, input ready);
  modport sink   (input valid, input word_first, input word_second, output ready);
endinterface

interface rgbc_cfg_if import rgbc_pkg::*; ();
  logic      valid;
  logic      ready;
  cfg_idx_t  index;
  cfg_data_t data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/core/rgb32_pixel_format_converter.sv =====
// Top level of the RGB pixel format converter: a three-stage pipeline turning
// pairs of 24-bit RGB pixels into UYVY or RGB565 words. Depends on rgbc_pkg, rgbc_ifs.
//
//   Channel   Direction  Carries
//   cfg_ch    in         register index and write data (always ready)
//   in_ch     in         pixel_first, pixel_second (one pixel pair per item)
//   out_ch    out        word_first, word_second (one result item per input item)
//
// One item enters per clock while out_ch is not stalled; each item passes through three
// register stages in order: products, sums, packing.
// rst_n is synchronous and active low; it empties the pipeline and clears both registers.
// Each stage keeps its item while the next stage is full and stalled, so a held output
// still lets earlier bubbles fill; nothing is lost or repeated.
module rgb32_pixel_format_converter
  import rgbc_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  rgbc_cfg_if.sink           cfg_ch,
  rgbc_pix_if.sink           in_ch,
  rgbc_word_if.source        out_ch
);

  // Configuration registers. The user must see that they are written only while the block
  // is idle; the block does not enforce it, and so the packing stage can read them directly.
  logic fmt_r, fmt_nxt;
  logic big_r, big_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    fmt_nxt = fmt_r;
    big_nxt = big_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_OUTPUT_FORMAT:   fmt_nxt = cfg_ch.data[0];
        CFG_WORD_BYTE_ORDER: big_nxt = cfg_ch.data[0];
        default: begin
          fmt_nxt = fmt_r;
          big_nxt = big_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r <= FMT_UYVY;
      big_r <= 1'b0;
    end else begin
      fmt_r <= fmt_nxt;
      big_r <= big_nxt;
    end
  end

  // Stage valid bits and advance conditions. A stage takes a new item when it is
  // empty or when its current item moves on in the same cycle.
  logic v1_r, v1_nxt;
  logic v2_r, v2_nxt;
  logic v3_r, v3_nxt;
  logic adv1, adv2, adv3;

  assign adv3 = !v3_r || out_ch.ready;
  assign adv2 = !v2_r || adv3;
  assign adv1 = !v1_r || adv2;

  assign in_ch.ready = adv1;

  // Stage 1: the nine coefficient products of each pixel.
  prod_t p1a_r, p1a_nxt;
  prod_t p1b_r, p1b_nxt;
  // Stage 2: the biased sums reduced to 8-bit Y, U and V.
  yuv_t  c2a_r, c2a_nxt;
  yuv_t  c2b_r, c2b_nxt;
  // Stage 3: the output words, held until the sink takes them.
  word_t w3a_r, w3a_nxt;
  word_t w3b_r, w3b_nxt;

  always_comb begin
    v1_nxt  = adv1 ? in_ch.valid : v1_r;
    v2_nxt  = adv2 ? v1_r : v2_r;
    v3_nxt  = adv3 ? v2_r : v3_r;

    p1a_nxt = p1a_r;
    p1b_nxt = p1b_r;
    c2a_nxt = c2a_r;
    c2b_nxt = c2b_r;
    w3a_nxt = w3a_r;
    w3b_nxt = w3b_r;

    if (adv1 && in_ch.valid) begin
      p1a_nxt = pixel_products(in_ch.pixel_first);
      p1b_nxt = pixel_products(in_ch.pixel_second);
    end
    if (adv2 && v1_r) begin
      c2a_nxt = pixel_sums(p1a_r);
      c2b_nxt = pixel_sums(p1b_r);
    end
    if (adv3 && v2_r) begin
      w3a_nxt = pixel_pack(c2a_r, fmt_r, big_r);
      w3b_nxt = pixel_pack(c2b_r, fmt_r, big_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  // Payload registers need no reset; the valid bits qualify them.
  always_ff @(posedge clk) begin
    p1a_r <= p1a_nxt;
    p1b_r <= p1b_nxt;
    c2a_r <= c2a_nxt;
    c2b_r <= c2b_nxt;
    w3a_r <= w3a_nxt;
    w3b_r <= w3b_nxt;
  end

  assign out_ch.valid       = v3_r;
  assign out_ch.word_first  = w3a_r;
  assign out_ch.word_second = w3b_r;

endmodule

// ===== tb/sv/rgb32_pixel_format_converter_tb.sv =====
// Self-checking testbench for rgb32_pixel_format_converter: directed and random pixel
// pairs under every output format and byte order, with bursty input and a stalling output.
// Depends on rgbc_pkg and the channel interfaces in rgbc_ifs.
`timescale 1ns / 100ps

module rgb32_pixel_format_converter_tb;
  import rgbc_pkg::*;

  // Three register stages sit between an accepted item and its result.
  localparam int PIPE_LATENCY  = 3;
  localparam int SETTLE_CYCLES = 4 * PIPE_LATENCY;
  localparam int RESET_CYCLES  = 7;
  localparam int LONG_HOLD     = 100;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 142;
  localparam int MAX_REPORTS   = 10;

  // Pixels that pin the converter at its corners: black and white, the primaries and
  // their complements (the extremes of U and V), alternating bit patterns, a pair of
  // equal pixels, and RGB565 cut points that set or clear the dropped low bits.
  localparam pixel_t EDGE_PIXELS [16] = '{
    24'h000000, 24'hFFFFFF,
    24'hFF0000, 24'h00FF00,
    24'h0000FF, 24'hFFFF00,
    24'h00FFFF, 24'hFF00FF,
    24'hAAAAAA, 24'h555555,
    24'h123456, 24'h123456,
    24'hF8FCF8, 24'h070307,
    24'h800080, 24'h7F807F
  };

  typedef struct {
    pixel_t first;
    pixel_t second;
  } pixel_pair_t;

  typedef struct {
    word_t first;
    word_t second;
  } word_pair_t;

  logic clk = 1'b0;
  logic rst_n;

  rgbc_cfg_if  cfg_ch ();
  rgbc_pix_if  in_ch ();
  rgbc_word_if out_ch ();

  rgb32_pixel_format_converter i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch.sink),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  always #5 clk = ~clk;

  // Pixel pairs waiting to be offered, and the converted words still owed by the block.
  pixel_pair_t pending_pairs [$];
  word_pair_t  expected_words [$];

  // Our own copy of the two configuration registers, updated on each accepted write.
  logic fmt_reg   = FMT_UYVY;
  logic order_reg = 1'b0;

  int   mismatch_count = 0;
  logic pair_accepted  = 1'b0;

  // The stimulus process asks for a long receiver hold-off by bumping this counter.
  int hold_requests = 0;

  // Converts one 24-bit pixel the way the block should. In UYVY mode the BT.601 integer
  // sums never leave 0..65535, so taking bits 15:8 of the plain integer sum is exact.
  function automatic word_t convert_pixel(pixel_t px, logic fmt, logic big);
    int         r;
    int         g;
    int         b;
    logic [7:0] y;
    logic [7:0] u;
    logic [7:0] v;
    r = int'(px[23:16]);
    g = int'(px[15:8]);
    b = int'(px[7:0]);
    if (fmt == FMT_RGB565) begin
      // Byte order has no say here and the upper halfword stays clear.
      return {16'd0, px[23:19], px[15:10], px[7:3]};
    end
    y = 8'((66 * r + 129 * g + 25 * b + 16 * 256 + 128) >> 8);
    u = 8'((112 * b - 38 * r - 74 * g + 128 * 256 + 128) >> 8);
    v = 8'((112 * r - 94 * g - 18 * b + 128 * 256 + 128) >> 8);
    if (big) begin
      return {u, y, v, y};
    end
    return {y, v, y, u};
  endfunction

  task automatic report_mismatch(string field, word_t want, word_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s expected %08h, got %08h (format %0d, order %0d)",
               $realtime, field, want, got, fmt_reg, order_reg);
    end
  endtask

  // Monitor. Everything is sampled at the rising edge, when the testbench's own inputs
  // have been stable for half a period. The driver reads pair_accepted at the next
  // falling edge to decide whether the item on the bus has gone.
  always @(posedge clk) begin
    word_pair_t want;
    pair_accepted = 1'b0;
    if (!rst_n) begin
      fmt_reg   = FMT_UYVY;
      order_reg = 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_OUTPUT_FORMAT: begin
            fmt_reg = cfg_ch.data[0];
          end
          CFG_WORD_BYTE_ORDER: begin
            order_reg = cfg_ch.data[0];
          end
          default: begin
          end
        endcase
      end
      // A result can never belong to an item taken at the same edge, so checking it
      // before recording the new expectation is safe.
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: result %08h %08h arrived with nothing expected",
                     $realtime, out_ch.word_first, out_ch.word_second);
          end
        end else begin
          want = expected_words.pop_front();
          if (out_ch.word_first !== want.first) begin
            report_mismatch("word_first", want.first, out_ch.word_first);
          end
          if (out_ch.word_second !== want.second) begin
            report_mismatch("word_second", want.second, out_ch.word_second);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        want.first  = convert_pixel(in_ch.pixel_first, fmt_reg, order_reg);
        want.second = convert_pixel(in_ch.pixel_second, fmt_reg, order_reg);
        expected_words.push_back(want);
        pair_accepted = 1'b1;
      end
    end
  end

  // Driver. It offers pairs in bursts of random length with random gaps between them.
  // An offered item stays on the bus unchanged until it is accepted; a gap of zero
  // chains bursts together into long stretches with no idling at all.
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk) begin
    pixel_pair_t pair;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || pair_accepted) begin
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pending_pairs.size() != 0) begin
        pair = pending_pairs.pop_front();
        in_ch.pixel_first  <= pair.first;
        in_ch.pixel_second <= pair.second;
        in_ch.valid        <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(32, 96)
                                                   : $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver. Ready follows a 16-bit stall pattern that is redrawn after every lap:
  // sometimes all ones, sometimes random, sometimes mostly ready, sometimes mostly
  // stalled. On request it holds ready low for a long stretch that it counts itself,
  // so the pipeline fills and the block has to refuse input.
  logic [15:0] stall_pattern = '1;
  logic [3:0]  pattern_pos   = '0;
  int          hold_left     = 0;
  int          hold_served   = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = LONG_HOLD - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= stall_pattern[pattern_pos];
      pattern_pos++;
      if (pattern_pos == 4'd0) begin
        case ($urandom_range(0, 3))
          0: stall_pattern = '1;
          1: stall_pattern = 16'($urandom);
          2: stall_pattern = 16'($urandom | $urandom);
          default: stall_pattern = 16'($urandom & $urandom);
        endcase
      end
    end
  end

  // Registers are written at a falling edge and held until the rising edge that takes
  // them. Callers only do this while the block is idle.
  task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Holds the sender back until every queued item has been taken and every result has
  // come out, then lets the pipeline settle.
  task automatic wait_idle();
    while (pending_pairs.size() != 0 || in_ch.valid || expected_words.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Mostly uniform pixels; now and then some channels are pinned to 00 or FF so the
  // extremes of Y, U and V and the RGB565 field edges come up often.
  function automatic pixel_t random_pixel();
    pixel_t px;
    px = 24'($urandom_range(0, 24'hFFFFFF));
    if ($urandom_range(0, 5) == 0) begin
      for (int c = 0; c < 3; c++) begin
        case ($urandom_range(0, 2))
          0: px[c*8 +: 8] = 8'h00;
          1: px[c*8 +: 8] = 8'hFF;
          default: begin
          end
        endcase
      end
    end
    return px;
  endfunction

  task automatic queue_edge_pairs();
    pixel_pair_t pair;
    for (int k = 0; k < 8; k++) begin
      pair.first  = EDGE_PIXELS[2*k];
      pair.second = EDGE_PIXELS[2*k + 1];
      pending_pairs.push_back(pair);
    end
  endtask

  // Stimulus and sequencing.
  initial begin
    pixel_pair_t pair;
    logic        new_fmt;
    logic        new_order;
    rst_n              = 1'b0;
    in_ch.valid        = 1'b0;
    in_ch.pixel_first  = '0;
    in_ch.pixel_second = '0;
    out_ch.ready       = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = CFG_OUTPUT_FORMAT;
    cfg_ch.data        = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part. The edge pairs go through first with the reset settings (UYVY,
    // little-endian layout), then big-endian UYVY, then RGB565 with the byte order
    // still set, which must have no effect there.
    queue_edge_pairs();
    wait_idle();
    write_reg(CFG_WORD_BYTE_ORDER, 1'b1);
    queue_edge_pairs();
    wait_idle();
    write_reg(CFG_OUTPUT_FORMAT, FMT_RGB565);
    queue_edge_pairs();
    wait_idle();

    // Random part. The first four phases walk every format and byte order setting;
    // later ones draw a setting and may rewrite only one of the two registers. Each
    // phase ends with the sender paused until the block has delivered everything.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase < 4) begin
        new_fmt   = phase[1] ? FMT_RGB565 : FMT_UYVY;
        new_order = phase[0];
        write_reg(CFG_OUTPUT_FORMAT, new_fmt);
        write_reg(CFG_WORD_BYTE_ORDER, new_order);
      end else begin
        new_fmt   = $urandom_range(0, 1) ? FMT_RGB565 : FMT_UYVY;
        new_order = 1'($urandom_range(0, 1));
        case ($urandom_range(0, 2))
          0: write_reg(CFG_OUTPUT_FORMAT, new_fmt);
          1: write_reg(CFG_WORD_BYTE_ORDER, new_order);
          default: begin
            write_reg(CFG_WORD_BYTE_ORDER, new_order);
            write_reg(CFG_OUTPUT_FORMAT, new_fmt);
          end
        endcase
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pair.first  = random_pixel();
        pair.second = ($urandom_range(0, 7) == 0) ? pair.first : random_pixel();
        pending_pairs.push_back(pair);
      end
      // With a whole phase queued up, a long output hold-off makes the sender keep
      // offering into a full pipeline.
      if (phase % 4 == 1) begin
        hold_requests++;
      end
      wait_idle();
    end

    if (mismatch_count == 0) begin
      $display("rgb32_pixel_format_converter: match");
    end else begin
      $display("rgb32_pixel_format_converter: mismatch");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this.
  initial begin
    #2_000_000;
    $display("rgb32_pixel_format_converter: mismatch");
    $finish;
  end

endmodule
